FILE: src/iiel_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed insert/erase list package
// Command codes, field widths and the shift control bundle that the top level
// hands to every storage cell.
// ----------------------------------------------------------------------------
package iiel_pkg;

    localparam int CMD_W   = 2;
    localparam int POS_W   = 8;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 7;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // Broadcast to all cells in the cycle a command is accepted.
    typedef struct packed {
        logic              ins;
        logic              ers;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } t_shift_ctl;

endpackage

FILE: src/iiel_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// List storage cell
// Holds one entry. On insert, cells past the index take the left neighbor's
// word (the cell at it takes the new word); on erase cells from it shift left.
// ----------------------------------------------------------------------------
module iiel_cell #(
    parameter int IDX = 0
) (
    input  logic                             i_clk,
    input  iiel_pkg::t_shift_ctl             i_ctl,
    input  logic signed [iiel_pkg::DATA_W-1:0] i_left,
    input  logic signed [iiel_pkg::DATA_W-1:0] i_right,
    output logic signed [iiel_pkg::DATA_W-1:0] o_data,
    output logic signed [iiel_pkg::DATA_W-1:0] o_rd
);

    localparam int IW = $clog2(IDX + 2);
    localparam int CW = (iiel_pkg::POS_W > IW) ? iiel_pkg::POS_W : IW;
    localparam logic [CW-1:0] IDX_V = CW'(IDX);

    logic [CW-1:0]                       w_pos;
    logic                                w_gt;
    logic                                w_eq;
    logic signed [iiel_pkg::DATA_W-1:0]  r_data;
    logic signed [iiel_pkg::DATA_W-1:0]  n_data;

    assign w_pos = CW'(i_ctl.pos);
    assign w_gt  = IDX_V > w_pos;
    assign w_eq  = IDX_V == w_pos;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins && w_gt) begin
            n_data = i_left;
        end else if (i_ctl.ins && w_eq) begin
            n_data = i_ctl.value;
        end else if (i_ctl.ers && (w_gt || w_eq)) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_rd   = w_eq ? r_data : '0;

endmodule

FILE: src/indexed_insert_erase_list.sv
`timescale 1ns / 1ps
// A result is presented in the cycle after its command is accepted.
// Throughput: one command per cycle while o_ready is high; all cells shift
// in parallel, so an insert or erase needs no extra time at any position.
// The output register decouples the sides; o_ready drops only while a result
// is held and i_ready is low. Synchronous active-low reset empties the list
// (fill = 0) and clears the output valid; entry words are not reset.
// ----------------------------------------------------------------------------
// Indexed insert/erase list
// Ordered list of signed words built as a chain of storage cells with a fill
// counter and a registered result stage.
// ----------------------------------------------------------------------------
module indexed_insert_erase_list #(
    parameter int CAPACITY = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [iiel_pkg::CMD_W-1:0]          i_cmd,
    input  logic [iiel_pkg::POS_W-1:0]          i_position,
    input  logic signed [iiel_pkg::DATA_W-1:0]  i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_ok,
    output logic signed [iiel_pkg::DATA_W-1:0]  o_read_value,
    output logic [iiel_pkg::COUNT_W-1:0]        o_count
);

    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = (iiel_pkg::POS_W > FW) ? iiel_pkg::POS_W : FW;
    localparam logic [FW-1:0] CAP_V = FW'(CAPACITY);

    logic [FW-1:0]                       r_fill;
    logic [FW-1:0]                       n_fill;
    logic                                r_out_valid;
    logic                                r_ok;
    logic signed [iiel_pkg::DATA_W-1:0]  r_rd;
    logic [iiel_pkg::COUNT_W-1:0]        r_count;

    logic                                w_acc;
    logic [CW-1:0]                       w_pos;
    logic [CW-1:0]                       w_fill;
    logic                                w_ins_ok;
    logic                                w_ers_ok;
    logic                                w_rd_ok;
    logic signed [iiel_pkg::DATA_W-1:0]  w_rd_sel;
    iiel_pkg::t_shift_ctl                w_ctl;

    logic signed [iiel_pkg::DATA_W-1:0]  w_data [CAPACITY];
    logic signed [iiel_pkg::DATA_W-1:0]  w_rd   [CAPACITY];

    assign o_ready = !r_out_valid || i_ready;
    assign w_acc   = i_valid && o_ready;
    assign w_pos   = CW'(i_position);
    assign w_fill  = CW'(r_fill);

    assign w_ins_ok = (i_cmd == iiel_pkg::CMD_INSERT) && (w_pos <= w_fill) && (r_fill < CAP_V);
    assign w_ers_ok = (i_cmd == iiel_pkg::CMD_ERASE) && (w_pos < w_fill);
    assign w_rd_ok  = (i_cmd == iiel_pkg::CMD_READ) && (w_pos < w_fill);

    assign w_ctl.ins   = w_acc && w_ins_ok;
    assign w_ctl.ers   = w_acc && w_ers_ok;
    assign w_ctl.pos   = i_position;
    assign w_ctl.value = i_value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        iiel_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_left  ((g == 0) ? i_value : w_data[(g == 0) ? 0 : g - 1]),
            .i_right ((g == CAPACITY - 1) ? w_data[g] : w_data[(g == CAPACITY - 1) ? g : g + 1]),
            .o_data  (w_data[g]),
            .o_rd    (w_rd[g])
        );
    end

    // Only the addressed cell drives a nonzero word.
    always_comb begin
        w_rd_sel = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd_sel = w_rd_sel | w_rd[k];
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (w_ctl.ins) begin
            n_fill = r_fill + FW'(1);
        end else if (w_ctl.ers) begin
            n_fill = r_fill - FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ok    <= w_ins_ok || w_ers_ok || w_rd_ok;
            r_rd    <= w_rd_ok ? w_rd_sel : '0;
            r_count <= iiel_pkg::COUNT_W'(n_fill);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_ok         = r_ok;
    assign o_read_value = r_rd;
    assign o_count      = r_count;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CAP_V)
        else $error("fill exceeds capacity");

    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_ins_ok |=> r_fill == $past(r_fill) + FW'(1))
        else $error("successful insert did not grow the list");

    a_ers_shrink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_ers_ok |=> r_fill == $past(r_fill) - FW'(1))
        else $error("successful erase did not shrink the list");

    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && !w_ins_ok && !w_ers_ok |=> r_fill == $past(r_fill))
        else $error("fill changed on a transaction that does not resize");

    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_read_value == '0)
        else $error("rejected transaction carries a read word");
`endif

endmodule
